// File: hdl/motor_reply_frame_parser_unit_defines.svh
// Assertion macros for the motor reply frame parser.
`ifndef MOTOR_REPLY_FRAME_PARSER_UNIT_DEFINES_SVH
`define MOTOR_REPLY_FRAME_PARSER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MRFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MRFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mrfp_pkg.sv
// Shared constants, codes and types of the motor reply frame parser.
package mrfp_pkg;

  localparam logic [7:0] HDR_BYTE  = 8'h3E;
  localparam logic [7:0] CMD_POS   = 8'h90;
  localparam logic [7:0] CMD_ANGLE = 8'h92;
  localparam logic [7:0] ANGLE_LEN = 8'h08;

  localparam logic [3:0] POS_FRAME_LEN   = 4'd12;
  localparam logic [3:0] ANGLE_FRAME_LEN = 4'd14;
  localparam logic [3:0] POS_LAST        = POS_FRAME_LEN - 4'd1;
  localparam logic [3:0] ANGLE_LAST      = ANGLE_FRAME_LEN - 4'd1;

  localparam logic [3:0] BP_HUNT = 4'd0;
  localparam logic [3:0] BP_CMD  = 4'd1;
  localparam logic [3:0] BP_ID   = 4'd2;
  localparam logic [3:0] BP_LEN  = 4'd3;
  localparam logic [3:0] BP_HSUM = 4'd4;
  localparam logic [3:0] BP_DATA = 4'd5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HDR_ERR  = 2'd1,
    ST_LEN_ERR  = 2'd2,
    ST_DATA_ERR = 2'd3
  } status_e;

  typedef struct packed {
    status_e            status;
    logic               frame_kind;
    logic [7:0]         motor_id;
    logic [15:0]        encoder_position;
    logic [15:0]        encoder_raw;
    logic [15:0]        encoder_offset;
    logic signed [63:0] motor_angle;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } result_msg_t;

endpackage

// File: hdl/mrfp_core.sv
// Frame tracking, checksums and data capture for one word per cycle on word_fire_i.
module mrfp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 word_fire_i,
  input  logic [7:0]           rx_byte_i,
  output mrfp_pkg::result_msg_t msg_o
);

  logic [3:0]  pos_q, pos_d;
  logic        kind_q, kind_d;
  logic [7:0]  hsum_q, hsum_d;
  logic [7:0]  psum_q, psum_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  len_q, len_d;
  logic [63:0] payload_q;
  logic        pay_we;
  logic [3:0]  lane_full;
  logic [2:0]  lane;
  logic [3:0]  last_pos;
  logic        msg_valid;
  mrfp_pkg::result_t res;
  mrfp_pkg::status_e status;

  assign lane_full = pos_q - mrfp_pkg::BP_DATA;
  assign lane      = lane_full[2:0];
  assign last_pos  = kind_q ? mrfp_pkg::ANGLE_LAST : mrfp_pkg::POS_LAST;

  always_comb begin
    pos_d     = pos_q;
    kind_d    = kind_q;
    hsum_d    = hsum_q;
    psum_d    = psum_q;
    id_d      = id_q;
    len_d     = len_q;
    pay_we    = 1'b0;
    msg_valid = 1'b0;
    if (word_fire_i) begin
      case (pos_q)
        mrfp_pkg::BP_HUNT: begin
          if (rx_byte_i == mrfp_pkg::HDR_BYTE) begin
            pos_d  = mrfp_pkg::BP_CMD;
            hsum_d = mrfp_pkg::HDR_BYTE;
          end
        end
        mrfp_pkg::BP_CMD: begin
          if (rx_byte_i == mrfp_pkg::CMD_POS || rx_byte_i == mrfp_pkg::CMD_ANGLE) begin
            kind_d = (rx_byte_i == mrfp_pkg::CMD_ANGLE);
            hsum_d = hsum_q + rx_byte_i;
            psum_d = 8'd0;
            pos_d  = mrfp_pkg::BP_ID;
          end else if (rx_byte_i == mrfp_pkg::HDR_BYTE) begin
            pos_d  = mrfp_pkg::BP_CMD;
            hsum_d = mrfp_pkg::HDR_BYTE;
          end else begin
            pos_d = mrfp_pkg::BP_HUNT;
          end
        end
        mrfp_pkg::BP_ID: begin
          id_d   = rx_byte_i;
          hsum_d = hsum_q + rx_byte_i;
          pos_d  = mrfp_pkg::BP_LEN;
        end
        mrfp_pkg::BP_LEN: begin
          len_d  = rx_byte_i;
          hsum_d = hsum_q + rx_byte_i;
          pos_d  = mrfp_pkg::BP_HSUM;
        end
        mrfp_pkg::BP_HSUM: begin
          hsum_d = hsum_q ^ rx_byte_i;
          pos_d  = mrfp_pkg::BP_DATA;
        end
        default: begin
          if (pos_q < last_pos) begin
            psum_d = psum_q + rx_byte_i;
            pay_we = 1'b1;
            pos_d  = pos_q + 4'd1;
          end else begin
            msg_valid = 1'b1;
            pos_d     = mrfp_pkg::BP_HUNT;
          end
        end
      endcase
    end
  end

  // The checks are ranked: header sum first, then length, then data sum.
  always_comb begin
    if (hsum_q != 8'd0) begin
      status = mrfp_pkg::ST_HDR_ERR;
    end else if (kind_q && len_q != mrfp_pkg::ANGLE_LEN) begin
      status = mrfp_pkg::ST_LEN_ERR;
    end else if (psum_q != rx_byte_i) begin
      status = mrfp_pkg::ST_DATA_ERR;
    end else begin
      status = mrfp_pkg::ST_OK;
    end
  end

  always_comb begin
    res.status           = status;
    res.frame_kind       = kind_q;
    res.motor_id         = id_q;
    res.encoder_position = 16'd0;
    res.encoder_raw      = 16'd0;
    res.encoder_offset   = 16'd0;
    res.motor_angle      = 64'sd0;
    if (status == mrfp_pkg::ST_OK) begin
      if (kind_q) begin
        res.motor_angle = $signed(payload_q);
      end else begin
        res.encoder_position = payload_q[15:0];
        res.encoder_raw      = payload_q[31:16];
        res.encoder_offset   = payload_q[47:32];
      end
    end
  end

  assign msg_o = '{valid: msg_valid, res: res};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= mrfp_pkg::BP_HUNT;
      kind_q <= 1'b0;
      hsum_q <= 8'd0;
      psum_q <= 8'd0;
      id_q   <= 8'd0;
      len_q  <= 8'd0;
    end else begin
      pos_q  <= pos_d;
      kind_q <= kind_d;
      hsum_q <= hsum_d;
      psum_q <= psum_d;
      id_q   <= id_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      payload_q[{lane, 3'b000} +: 8] <= rx_byte_i;
    end
  end

endmodule

// File: hdl/motor_reply_frame_parser_unit.sv
// Top level of the motor reply frame parser with its result buffering.
// Usage: received bytes enter on the input channel (in_valid_i, rx_byte_i,
// in_stall_o), one word per cycle while not stalled. The parser hunts for
// the 0x3E header, follows 12-word position frames and 14-word angle frames,
// and checks the header and data sums. The last word of each frame yields
// one result on the output channel (out_valid_o, the result fields,
// out_stall_i), registered in the output register or, while it holds a
// result, in the skid register. Unstalled, the block takes one word every
// cycle; each word needs only a sum and a position update in the parser core.
// When the receiver stalls, the output register holds its result and one
// more result can wait in a skid register, so words keep flowing until a
// second result is pending; only then is in_stall_o raised.
// Reset clears the frame state to header hunting and empties both result
// registers; in_stall_o is low right after reset.
`include "motor_reply_frame_parser_unit_defines.svh"
module motor_reply_frame_parser_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic               frame_kind_o,
  output logic [7:0]         motor_id_o,
  output logic [15:0]        encoder_position_o,
  output logic [15:0]        encoder_raw_o,
  output logic [15:0]        encoder_offset_o,
  output logic signed [63:0] motor_angle_o
);

  logic                  in_fire;
  logic                  out_fire;
  mrfp_pkg::result_msg_t core_msg;
  logic                  out_valid_q, out_valid_d;
  logic                  skid_valid_q, skid_valid_d;
  mrfp_pkg::result_t     out_res_q, out_res_d;
  mrfp_pkg::result_t     skid_res_q, skid_res_d;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  mrfp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .word_fire_i(in_fire),
    .rx_byte_i  (rx_byte_i),
    .msg_o      (core_msg)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_res_d    = out_res_q;
    skid_res_d   = skid_res_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_res_d    = skid_res_q;
        skid_valid_d = 1'b0;
      end
    end else if (core_msg.valid) begin
      if (!out_valid_q || out_fire) begin
        out_res_d   = core_msg.res;
        out_valid_d = 1'b1;
      end else begin
        skid_res_d   = core_msg.res;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_res_q.status;
  assign frame_kind_o       = out_res_q.frame_kind;
  assign motor_id_o         = out_res_q.motor_id;
  assign encoder_position_o = out_res_q.encoder_position;
  assign encoder_raw_o      = out_res_q.encoder_raw;
  assign encoder_offset_o   = out_res_q.encoder_offset;
  assign motor_angle_o      = out_res_q.motor_angle;

  `MRFP_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with empty output")
  `MRFP_ASSERT_NOW(a_err_fields_zero,
    out_valid_o && status_o != mrfp_pkg::ST_OK,
    encoder_position_o == 16'd0 && encoder_raw_o == 16'd0 && encoder_offset_o == 16'd0
      && motor_angle_o == 64'sd0,
    "error result carries data")
  `MRFP_ASSERT_NOW(a_pos_no_angle, out_valid_o && !frame_kind_o, motor_angle_o == 64'sd0,
    "position frame carries an angle")
  `MRFP_ASSERT_NEXT(a_skid_fills_on_block, out_valid_q && out_stall_i && !skid_valid_q
    && core_msg.valid, skid_valid_q && out_valid_q, "result lost while output blocked")

endmodule
